// File: src/fpbm_pkg.sv
// ----------------------------------------------------------------------------
// fpbm_pkg
// Shared types and constants of the flash page and block metadata table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpbm_pkg;

  localparam int NUM_BLOCKS      = 256;
  localparam int PAGES_PER_BLOCK = 64;
  localparam int LPN_BITS        = 16;

  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int OFF_W       = $clog2(PAGES_PER_BLOCK);
  localparam int PAGE_W      = BLK_W + OFF_W;
  localparam int CNT_W       = $clog2(PAGES_PER_BLOCK + 1);
  localparam int TOT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int ERASE_W     = 32;
  localparam int TOTAL_PAGES = NUM_BLOCKS * PAGES_PER_BLOCK;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_INVAL  = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_OPEN   = 3'd3,
    ACT_RETIRE = 3'd4,
    ACT_LOOKUP = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BLK_STATE = 3'd1,
    STS_PG_STATE  = 3'd2,
    STS_LPN_MISS  = 3'd3,
    STS_RANGE     = 3'd4,
    STS_ERASE_BLK = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PG_FREE = 2'd0,
    PG_LIVE = 2'd1,
    PG_DEAD = 2'd2
  } page_state_t;

  typedef enum logic [1:0] {
    BK_FREE = 2'd0,
    BK_HEAD = 2'd1,
    BK_BODY = 2'd2,
    BK_TAIL = 2'd3
  } block_state_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  // One block record as held in the block memory.
  typedef struct packed {
    block_state_t         state;
    logic [OFF_W-1:0]     wo;
    logic [CNT_W-1:0]     free_cnt;
    logic [CNT_W-1:0]     live_cnt;
    logic [CNT_W-1:0]     dead_cnt;
    logic [ERASE_W-1:0]   erases;
  } blk_rec_t;

  localparam int BLK_REC_W = $bits(blk_rec_t);

  // One page record as held in the page memory.
  typedef struct packed {
    page_state_t          state;
    logic [LPN_BITS-1:0]  lpn;
  } page_rec_t;

  localparam int PAGE_REC_W = $bits(page_rec_t);

  typedef struct packed {
    logic [2:0]           action;
    logic [BLK_W-1:0]     block;
    logic [PAGE_W-1:0]    page_addr;
    logic [LPN_BITS-1:0]  lpn;
    logic                 is_dummy;
    logic                 check_lpn;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [PAGE_W-1:0]    page_out;
    logic [LPN_BITS-1:0]  lpn_out;
    logic                 lpn_valid;
    logic [1:0]           page_state_out;
    logic [1:0]           block_state_out;
    logic [CNT_W-1:0]     block_free_pages;
    logic [CNT_W-1:0]     block_live_pages;
    logic [CNT_W-1:0]     block_dead_pages;
    logic [ERASE_W-1:0]   block_erase_count;
    logic [TOT_W-1:0]     free_block_total;
    logic [TOT_W-1:0]     tail_block_total;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  localparam blk_rec_t BLK_REC_RESET = '{
    state:    BK_FREE,
    wo:       '0,
    free_cnt: CNT_W'(PAGES_PER_BLOCK),
    live_cnt: '0,
    dead_cnt: '0,
    erases:   '0
  };

endpackage

`default_nettype wire

// File: src/fpbm_if.sv
// ----------------------------------------------------------------------------
// fpbm_in_if / fpbm_out_if
// Valid/ready channels that carry request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpbm_in_if import fpbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           action;
  logic [BLK_W-1:0]     block;
  logic [PAGE_W-1:0]    page_addr;
  logic [LPN_BITS-1:0]  lpn;
  logic                 is_dummy;
  logic                 check_lpn;

  modport source (output valid, action, block, page_addr, lpn, is_dummy, check_lpn,
                  input ready);
  modport sink   (input valid, action, block, page_addr, lpn, is_dummy, check_lpn,
                  output ready);
endinterface

interface fpbm_out_if import fpbm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [PAGE_W-1:0]    page_out;
  logic [LPN_BITS-1:0]  lpn_out;
  logic                 lpn_valid;
  logic [1:0]           page_state_out;
  logic [1:0]           block_state_out;
  logic [CNT_W-1:0]     block_free_pages;
  logic [CNT_W-1:0]     block_live_pages;
  logic [CNT_W-1:0]     block_dead_pages;
  logic [ERASE_W-1:0]   block_erase_count;
  logic [TOT_W-1:0]     free_block_total;
  logic [TOT_W-1:0]     tail_block_total;

  modport source (output valid, status, page_out, lpn_out, lpn_valid, page_state_out,
                  block_state_out, block_free_pages, block_live_pages,
                  block_dead_pages, block_erase_count, free_block_total,
                  tail_block_total,
                  input ready);
  modport sink   (input valid, status, page_out, lpn_out, lpn_valid, page_state_out,
                  block_state_out, block_free_pages, block_live_pages,
                  block_dead_pages, block_erase_count, free_block_total,
                  tail_block_total,
                  output ready);
endinterface

`default_nettype wire

// File: src/flash_page_block_meta_table.sv
// ----------------------------------------------------------------------------
// flash_page_block_meta_table
// Flash page and block metadata table with page and block state, counts and
// erase counts, driven by one request beat at a time.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake     Beat
//   in_if    in   valid/ready   action, block, page, lpn, flags
//   out_if   out  valid/ready   status, page and block view, totals
//
// Each request first reads the block and page memories, then updates them
// and loads the result register.
// A stalled result holds the update cycle until the result register frees.
// Reset clears a valid bit per block and resets the totals; no clearing pass runs,
// page state of unwritten pages follows from the block record.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_page_block_meta_table import fpbm_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  fpbm_in_if.sink    in_if,
  fpbm_out_if.source out_if
);

  ctrl_cmd_t cmd;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item = '{
    action:    in_if.action,
    block:     in_if.block,
    page_addr: in_if.page_addr,
    lpn:       in_if.lpn,
    is_dummy:  in_if.is_dummy,
    check_lpn: in_if.check_lpn
  };

  fpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  fpbm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // Result fields.
  assign out_if.status            = out_item.status;
  assign out_if.page_out          = out_item.page_out;
  assign out_if.lpn_out           = out_item.lpn_out;
  assign out_if.lpn_valid         = out_item.lpn_valid;
  assign out_if.page_state_out    = out_item.page_state_out;
  assign out_if.block_state_out   = out_item.block_state_out;
  assign out_if.block_free_pages  = out_item.block_free_pages;
  assign out_if.block_live_pages  = out_item.block_live_pages;
  assign out_if.block_dead_pages  = out_item.block_dead_pages;
  assign out_if.block_erase_count = out_item.block_erase_count;
  assign out_if.free_block_total  = out_item.free_block_total;
  assign out_if.tail_block_total  = out_item.tail_block_total;

endmodule

`default_nettype wire

// File: src/fpbm_ram.sv
// ----------------------------------------------------------------------------
// fpbm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/fpbm_ctrl.sv
// ----------------------------------------------------------------------------
// fpbm_ctrl
// Controller: sequences the memory read and update of each request beat and
// owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbm_ctrl import fpbm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      ctrl_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.commit = out_free;
      default: ;
    endcase
  end

  // Result valid: set by a commit, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A loaded request is always followed by its update cycle.
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EXEC)
    else $error("load not followed by update state");

  // A stalled result holds the update back.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && !out_ready) |=> state_r == S_EXEC)
    else $error("update overran a stalled result");

  // A commit always presents a result next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

`default_nettype wire

// File: src/fpbm_dp.sv
// ----------------------------------------------------------------------------
// fpbm_dp
// Datapath: block and page memories, block valid bits, global counts and
// the result register. Reads on load, updates on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module fpbm_dp import fpbm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ctrl_cmd_t cmd,
  input  wire in_item_t  in_item,
  output      out_item_t out_item
);

  in_item_t          item_r;
  logic              blk_vld_r [NUM_BLOCKS];
  logic              rd_vld_r;
  logic [TOT_W-1:0]  free_tot_r, free_tot_nxt;
  logic [TOT_W-1:0]  tail_tot_r, tail_tot_nxt;
  out_item_t         out_r, out_nxt;

  logic [BLK_W-1:0]       rd_blk;
  logic [BLK_REC_W-1:0]   blk_rdata;
  logic [PAGE_REC_W-1:0]  page_rdata;
  blk_rec_t               rec, rec_nxt;
  page_rec_t              prec, prec_nxt;
  page_state_t            pst;
  logic                   page_act;
  logic [BLK_W-1:0]       e_blk;
  logic [OFF_W-1:0]       e_off;
  logic                   blk_we, page_we;
  logic [PAGE_W-1:0]      page_waddr;
  logic                   blk_ok, pg_ok, oor;
  status_t                status;
  logic [CNT_W-1:0]       free_dec;

  // Read address: page actions address the block that holds the page.
  always_comb begin
    if (in_item.action == ACT_INVAL || in_item.action == ACT_LOOKUP) begin
      rd_blk = in_item.page_addr[PAGE_W-1:OFF_W];
    end else begin
      rd_blk = in_item.block;
    end
  end

  fpbm_ram #(.WIDTH(BLK_REC_W), .DEPTH(NUM_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (e_blk),
    .wdata (rec_nxt),
    .re    (cmd.load),
    .raddr (rd_blk),
    .rdata (blk_rdata)
  );

  fpbm_ram #(.WIDTH(PAGE_REC_W), .DEPTH(TOTAL_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (prec_nxt),
    .re    (cmd.load),
    .raddr (in_item.page_addr),
    .rdata (page_rdata)
  );

  // Capture the request and the valid bit of its block.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_item;
      rd_vld_r <= blk_vld_r[rd_blk];
    end
  end

  // Block record: a never-written block reads as its reset value.
  assign page_act = (item_r.action == ACT_INVAL) || (item_r.action == ACT_LOOKUP);
  assign e_blk    = page_act ? item_r.page_addr[PAGE_W-1:OFF_W] : item_r.block;
  assign e_off    = item_r.page_addr[OFF_W-1:0];
  assign rec      = rd_vld_r ? blk_rec_t'(blk_rdata) : BLK_REC_RESET;
  assign prec     = page_rec_t'(page_rdata);
  assign free_dec = rec.free_cnt - CNT_W'(1);

  // Page state follows from the block: free blocks and the unwritten part
  // of a head block hold only free pages.
  always_comb begin
    if (rec.state == BK_FREE || (rec.state == BK_HEAD && e_off >= rec.wo)) begin
      pst = PG_FREE;
    end else begin
      pst = prec.state;
    end
  end

  // Action decode and update.
  always_comb begin
    status       = STS_OK;
    rec_nxt      = rec;
    prec_nxt     = '{state: pst, lpn: prec.lpn};
    blk_we       = 1'b0;
    page_we      = 1'b0;
    page_waddr   = item_r.page_addr;
    blk_ok       = 1'b1;
    pg_ok        = 1'b0;
    free_tot_nxt = free_tot_r;
    tail_tot_nxt = tail_tot_r;
    oor          = page_act ? (32'(item_r.page_addr) >= 32'(TOTAL_PAGES))
                            : (32'(item_r.block) >= 32'(NUM_BLOCKS));
    case (item_r.action)
      ACT_WRITE: begin
        if (rec.state != BK_HEAD) begin
          status = STS_BLK_STATE;
        end else begin
          page_waddr       = {item_r.block, rec.wo};
          pg_ok            = 1'b1;
          rec_nxt.free_cnt = free_dec;
          if (item_r.is_dummy) begin
            prec_nxt         = '{state: PG_DEAD, lpn: '0};
            rec_nxt.dead_cnt = rec.dead_cnt + CNT_W'(1);
          end else begin
            prec_nxt         = '{state: PG_LIVE, lpn: item_r.lpn};
            rec_nxt.live_cnt = rec.live_cnt + CNT_W'(1);
          end
          if (free_dec == '0) begin
            rec_nxt.wo    = '0;
            rec_nxt.state = BK_BODY;
          end else begin
            rec_nxt.wo = rec.wo + OFF_W'(1);
          end
          blk_we  = 1'b1;
          page_we = 1'b1;
        end
      end
      ACT_INVAL: begin
        pg_ok = 1'b1;
        if (pst != PG_LIVE) begin
          status = STS_PG_STATE;
        end else if (item_r.check_lpn && prec.lpn != item_r.lpn) begin
          status = STS_LPN_MISS;
        end else begin
          prec_nxt         = '{state: PG_DEAD, lpn: '0};
          rec_nxt.dead_cnt = rec.dead_cnt + CNT_W'(1);
          rec_nxt.live_cnt = rec.live_cnt - CNT_W'(1);
          blk_we           = 1'b1;
          page_we          = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (rec.state != BK_TAIL) begin
          status = STS_BLK_STATE;
        end else if (rec.live_cnt != '0 || rec.free_cnt != '0) begin
          status = STS_ERASE_BLK;
        end else begin
          rec_nxt        = BLK_REC_RESET;
          rec_nxt.erases = rec.erases + ERASE_W'(1);
          blk_we         = 1'b1;
          free_tot_nxt   = free_tot_r + TOT_W'(1);
          tail_tot_nxt   = tail_tot_r - TOT_W'(1);
        end
      end
      ACT_OPEN: begin
        if (rec.state != BK_FREE) begin
          status = STS_BLK_STATE;
        end else begin
          rec_nxt.state = BK_HEAD;
          blk_we        = 1'b1;
          free_tot_nxt  = free_tot_r - TOT_W'(1);
        end
      end
      ACT_RETIRE: begin
        if (rec.state != BK_BODY) begin
          status = STS_BLK_STATE;
        end else begin
          rec_nxt.state = BK_TAIL;
          blk_we        = 1'b1;
          tail_tot_nxt  = tail_tot_r + TOT_W'(1);
        end
      end
      ACT_LOOKUP: pg_ok = 1'b1;
      default: begin
        status = STS_RANGE;
        blk_ok = 1'b0;
      end
    endcase
    // Out of range requests change nothing.
    if (oor) begin
      status       = STS_RANGE;
      blk_ok       = 1'b0;
      pg_ok        = 1'b0;
      blk_we       = 1'b0;
      page_we      = 1'b0;
      free_tot_nxt = free_tot_r;
      tail_tot_nxt = tail_tot_r;
    end
    blk_we  = blk_we && cmd.commit;
    page_we = page_we && cmd.commit;
    if (!blk_we) begin
      rec_nxt = rec;
    end
  end

  // Result beat from the state after the action.
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = status;
    if (pg_ok) begin
      out_nxt.page_out       = page_waddr;
      out_nxt.page_state_out = prec_nxt.state;
      out_nxt.lpn_valid      = (prec_nxt.state == PG_LIVE);
      out_nxt.lpn_out        = (prec_nxt.state == PG_LIVE) ? prec_nxt.lpn : '0;
    end
    if (blk_ok) begin
      out_nxt.block_state_out   = rec_nxt.state;
      out_nxt.block_free_pages  = rec_nxt.free_cnt;
      out_nxt.block_live_pages  = rec_nxt.live_cnt;
      out_nxt.block_dead_pages  = rec_nxt.dead_cnt;
      out_nxt.block_erase_count = rec_nxt.erases;
    end
    out_nxt.free_block_total = free_tot_nxt;
    out_nxt.tail_block_total = tail_tot_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  // Global counts and block valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_tot_r <= TOT_W'(NUM_BLOCKS);
      tail_tot_r <= '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        blk_vld_r[i] <= 1'b0;
      end
    end else if (cmd.commit) begin
      free_tot_r <= free_tot_nxt;
      tail_tot_r <= tail_tot_nxt;
      if (blk_we) begin
        blk_vld_r[e_blk] <= 1'b1;
      end
    end
  end

  assign out_item = out_r;

  // Block counts never exceed the number of blocks.
  a_tot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_tot_r) + 32'(tail_tot_r)) <= 32'(NUM_BLOCKS))
    else $error("block totals out of range");

  // Memory writes happen only in a commit cycle.
  a_we_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_we || page_we) |-> cmd.commit)
    else $error("memory write outside commit");

  // A failed check never writes.
  a_fail_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (status != STS_OK) |-> !(blk_we || page_we))
    else $error("write on failed check");

endmodule

`default_nettype wire
